// ===== rtl/core/gated_greedy_point_tracker_defines.svh =====
// Assertion macros shared by the point tracker RTL.
// Included by the controller and datapath files; needs no other file.
`ifndef GATED_GREEDY_POINT_TRACKER_DEFINES_SVH
`define GATED_GREEDY_POINT_TRACKER_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define GGPT_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define GGPT_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== rtl/core/ggpt_pkg.sv =====
// Package of the point tracker: sizes, item and register codes, and the
// command and status structs between controller and datapath. No dependencies.
package ggpt_pkg;

	localparam int NUM_TRACKS    = 20;
	localparam int MAX_KEYPOINTS = 64;

	localparam int TRK_W     = (NUM_TRACKS > 1) ? $clog2(NUM_TRACKS) : 1;
	localparam int TRK_CNT_W = $clog2(NUM_TRACKS + 1);
	localparam int KP_IDX_W  = (MAX_KEYPOINTS > 1) ? $clog2(MAX_KEYPOINTS) : 1;
	localparam int KP_CNT_W  = $clog2(MAX_KEYPOINTS + 1);
	localparam int MM_W      = (TRK_CNT_W > 5) ? TRK_CNT_W : 5;

	localparam int S_DATA_W = 40;
	localparam int M_DATA_W = 80;

	localparam logic [1:0] KIND_INIT      = 2'd0;
	localparam logic [1:0] KIND_KEYPOINT  = 2'd1;
	localparam logic [1:0] KIND_FRAME_END = 2'd2;

	localparam logic [1:0] REG_CROP_X      = 2'd0;
	localparam logic [1:0] REG_CROP_Y      = 2'd1;
	localparam logic [1:0] REG_GATE        = 2'd2;
	localparam logic [1:0] REG_MIN_MATCHES = 2'd3;

	localparam logic [33:0] GATE_RESET        = 34'd102400;
	localparam logic [4:0]  MIN_MATCHES_RESET = 5'd20;

	typedef struct packed {
		logic                init_wr;
		logic                kp_wr;
		logic                frame_start;
		logic                kp_rd;
		logic                sub_en;
		logic                mul_en;
		logic                cmp_en;
		logic                out_load;
		logic                out_last;
		logic                clear_kp;
		logic [TRK_W-1:0]    trk;
		logic [KP_CNT_W-1:0] kp_q;
	} cmd_t;

	typedef struct packed {
		logic q_end;
		logic q_taken;
		logic hit;
		logic out_free;
	} sts_t;

endpackage

// ===== rtl/core/ggpt_datapath.sv =====
// Datapath of the point tracker: registers, track table, keypoint memory,
// distance pipeline and output register. Uses ggpt_pkg and the defines header.
`include "gated_greedy_point_tracker_defines.svh"

module ggpt_datapath (
	input  logic                           clk,
	input  logic                           arst_n,
	input  ggpt_pkg::cmd_t                 cmd,
	output ggpt_pkg::sts_t                 sts,
	input  logic [4:0]                     in_track_index,
	input  logic signed [15:0]             in_x,
	input  logic signed [15:0]             in_y,
	input  logic                           cfg_valid,
	input  logic [1:0]                     cfg_index,
	input  logic [33:0]                    cfg_data,
	output logic                           m_tvalid,
	input  logic                           m_tready,
	output logic [ggpt_pkg::M_DATA_W-1:0]  m_tdata,
	output logic                           m_tlast
);

	logic [14:0] crop_x_q;
	logic [14:0] crop_y_q;
	logic [33:0] gate_q;
	logic [4:0]  min_matches_q;

	logic signed [15:0] trk_x_q  [ggpt_pkg::NUM_TRACKS];
	logic signed [15:0] trk_y_q  [ggpt_pkg::NUM_TRACKS];
	logic signed [16:0] trk_vx_q [ggpt_pkg::NUM_TRACKS];
	logic signed [16:0] trk_vy_q [ggpt_pkg::NUM_TRACKS];
	logic [ggpt_pkg::NUM_TRACKS-1:0] found_q;

	logic signed [15:0] kp_x_mem [ggpt_pkg::MAX_KEYPOINTS];
	logic signed [15:0] kp_y_mem [ggpt_pkg::MAX_KEYPOINTS];
	logic [ggpt_pkg::MAX_KEYPOINTS-1:0] taken_q;
	logic [ggpt_pkg::KP_CNT_W-1:0]      kp_count_q;
	logic [ggpt_pkg::TRK_CNT_W-1:0]     match_cnt_q;

	logic signed [15:0] kp_rd_x_q, kp_rd_y_q;
	logic signed [16:0] dx_s1, dy_s1, dx_s2, dy_s2;
	logic signed [15:0] kp_x_s1, kp_y_s1, kp_x_s2, kp_y_s2;
	logic [31:0]        sqx_s2, sqy_s2;
	logic signed [33:0] sqx_full, sqy_full;
	logic [32:0]        d2;
	logic               hit;

	logic                            init_ok;
	logic [ggpt_pkg::TRK_W-1:0]      init_idx;
	logic                            kp_full;
	logic [ggpt_pkg::KP_IDX_W-1:0]   wr_idx;
	logic [ggpt_pkg::KP_IDX_W-1:0]   rd_idx;
	logic signed [16:0]              sum_x, sum_y;
	logic signed [15:0]              sat_x, sat_y;
	logic                            success;
	logic                            out_valid_q;

	assign init_ok  = 32'(in_track_index) < 32'(ggpt_pkg::NUM_TRACKS);
	assign init_idx = ggpt_pkg::TRK_W'(in_track_index);
	assign kp_full  = 32'(kp_count_q) >= 32'(ggpt_pkg::MAX_KEYPOINTS);
	assign wr_idx   = kp_count_q[ggpt_pkg::KP_IDX_W-1:0];
	assign rd_idx   = cmd.kp_q[ggpt_pkg::KP_IDX_W-1:0];

	// The origin is never negative, so only the upper bound can be crossed.
	assign sum_x = $signed({in_x[15], in_x}) + $signed({2'b00, crop_x_q});
	assign sum_y = $signed({in_y[15], in_y}) + $signed({2'b00, crop_y_q});
	assign sat_x = (!sum_x[16] && sum_x[15]) ? 16'sh7FFF : sum_x[15:0];
	assign sat_y = (!sum_y[16] && sum_y[15]) ? 16'sh7FFF : sum_y[15:0];

	assign sqx_full = dx_s1 * dx_s1;
	assign sqy_full = dy_s1 * dy_s1;
	assign d2       = {1'b0, sqx_s2} + {1'b0, sqy_s2};
	assign hit      = {1'b0, d2} < gate_q;

	assign success = ggpt_pkg::MM_W'(match_cnt_q) >= ggpt_pkg::MM_W'(min_matches_q);

	assign sts.q_end    = cmd.kp_q >= kp_count_q;
	assign sts.q_taken  = taken_q[rd_idx];
	assign sts.hit      = hit;
	assign sts.out_free = !out_valid_q || m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			crop_x_q      <= '0;
			crop_y_q      <= '0;
			gate_q        <= ggpt_pkg::GATE_RESET;
			min_matches_q <= ggpt_pkg::MIN_MATCHES_RESET;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				ggpt_pkg::REG_CROP_X:      crop_x_q      <= cfg_data[14:0];
				ggpt_pkg::REG_CROP_Y:      crop_y_q      <= cfg_data[14:0];
				ggpt_pkg::REG_GATE:        gate_q        <= cfg_data;
				ggpt_pkg::REG_MIN_MATCHES: min_matches_q <= cfg_data[4:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < ggpt_pkg::NUM_TRACKS; i++) begin
				trk_x_q[i]  <= '0;
				trk_y_q[i]  <= '0;
				trk_vx_q[i] <= '0;
				trk_vy_q[i] <= '0;
			end
			found_q <= '0;
		end else begin
			if (cmd.init_wr && init_ok) begin
				trk_x_q[init_idx]  <= in_x;
				trk_y_q[init_idx]  <= in_y;
				trk_vx_q[init_idx] <= '0;
				trk_vy_q[init_idx] <= '0;
				found_q[init_idx]  <= 1'b0;
			end
			if (cmd.frame_start) begin
				found_q <= '0;
			end
			if (cmd.cmp_en && hit) begin
				trk_x_q[cmd.trk]  <= kp_x_s2;
				trk_y_q[cmd.trk]  <= kp_y_s2;
				trk_vx_q[cmd.trk] <= dx_s2;
				trk_vy_q[cmd.trk] <= dy_s2;
				found_q[cmd.trk]  <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.kp_wr && !kp_full) begin
			kp_x_mem[wr_idx] <= sat_x;
			kp_y_mem[wr_idx] <= sat_y;
		end
		if (cmd.kp_rd) begin
			kp_rd_x_q <= kp_x_mem[rd_idx];
			kp_rd_y_q <= kp_y_mem[rd_idx];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			taken_q     <= '0;
			kp_count_q  <= '0;
			match_cnt_q <= '0;
		end else begin
			if (cmd.kp_wr && !kp_full) begin
				kp_count_q <= kp_count_q + 1'b1;
			end
			if (cmd.clear_kp) begin
				kp_count_q <= '0;
			end
			if (cmd.frame_start) begin
				taken_q     <= '0;
				match_cnt_q <= '0;
			end
			if (cmd.cmp_en && hit) begin
				taken_q[rd_idx] <= 1'b1;
				match_cnt_q     <= match_cnt_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.sub_en) begin
			dx_s1   <= $signed({kp_rd_x_q[15], kp_rd_x_q}) -
				$signed({trk_x_q[cmd.trk][15], trk_x_q[cmd.trk]});
			dy_s1   <= $signed({kp_rd_y_q[15], kp_rd_y_q}) -
				$signed({trk_y_q[cmd.trk][15], trk_y_q[cmd.trk]});
			kp_x_s1 <= kp_rd_x_q;
			kp_y_s1 <= kp_rd_y_q;
		end
		if (cmd.mul_en) begin
			sqx_s2  <= sqx_full[31:0];
			sqy_s2  <= sqy_full[31:0];
			dx_s2   <= dx_s1;
			dy_s2   <= dy_s1;
			kp_x_s2 <= kp_x_s1;
			kp_y_s2 <= kp_y_s1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.out_load) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			m_tdata <= {7'd0, success, found_q[cmd.trk], trk_vy_q[cmd.trk], trk_vx_q[cmd.trk],
				trk_y_q[cmd.trk], trk_x_q[cmd.trk], 5'(cmd.trk)};
			m_tlast <= cmd.out_last;
		end
	end

	assign m_tvalid = out_valid_q;

	`GGPT_ASSERT_NEXT(a_load_shows, clk, arst_n, cmd.out_load, m_tvalid, "loaded item not shown")
	`GGPT_ASSERT_NEXT(a_take_one, clk, arst_n, cmd.cmp_en && hit,
		$countones(taken_q) == $past($countones(taken_q)) + 1, "match did not take one keypoint")
	`GGPT_ASSERT_IMP(a_match_bound, clk, arst_n, 1'b1,
		32'(match_cnt_q) <= 32'(ggpt_pkg::NUM_TRACKS), "more matches than tracks")

endmodule

// ===== rtl/core/ggpt_ctrl.sv =====
// Controller of the point tracker: item decode, match sequencing over tracks
// and keypoints, and result emission. Uses ggpt_pkg and the defines header.
`include "gated_greedy_point_tracker_defines.svh"

module ggpt_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           s_tvalid,
	output logic           s_tready,
	input  logic [1:0]     kind,
	output ggpt_pkg::cmd_t cmd,
	input  ggpt_pkg::sts_t sts
);

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_RD   = 3'd1;
	localparam logic [2:0] ST_SUB  = 3'd2;
	localparam logic [2:0] ST_MUL  = 3'd3;
	localparam logic [2:0] ST_CMP  = 3'd4;
	localparam logic [2:0] ST_EMIT = 3'd5;

	logic [2:0]                    state_q;
	logic [ggpt_pkg::TRK_W-1:0]    trk_q;
	logic [ggpt_pkg::KP_CNT_W-1:0] kpq_q;
	logic                          accept;
	logic                          trk_last;

	assign s_tready = state_q == ST_IDLE;
	assign accept   = s_tvalid && s_tready;
	assign trk_last = trk_q == ggpt_pkg::TRK_W'(ggpt_pkg::NUM_TRACKS - 1);

	always_comb begin
		cmd      = '0;
		cmd.trk  = trk_q;
		cmd.kp_q = kpq_q;
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					case (kind)
						ggpt_pkg::KIND_INIT:      cmd.init_wr     = 1'b1;
						ggpt_pkg::KIND_KEYPOINT:  cmd.kp_wr       = 1'b1;
						ggpt_pkg::KIND_FRAME_END: cmd.frame_start = 1'b1;
						default: ;
					endcase
				end
			end
			ST_RD:  cmd.kp_rd  = !sts.q_end && !sts.q_taken;
			ST_SUB: cmd.sub_en = 1'b1;
			ST_MUL: cmd.mul_en = 1'b1;
			ST_CMP: cmd.cmp_en = 1'b1;
			ST_EMIT: begin
				cmd.out_load = sts.out_free;
				cmd.out_last = trk_last;
				cmd.clear_kp = sts.out_free && trk_last;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			trk_q   <= '0;
			kpq_q   <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (accept && kind == ggpt_pkg::KIND_FRAME_END) begin
						state_q <= ST_RD;
						trk_q   <= '0;
						kpq_q   <= '0;
					end
				end
				ST_RD: begin
					if (sts.q_end) begin
						kpq_q <= '0;
						if (trk_last) begin
							state_q <= ST_EMIT;
							trk_q   <= '0;
						end else begin
							trk_q <= trk_q + 1'b1;
						end
					end else if (sts.q_taken) begin
						kpq_q <= kpq_q + 1'b1;
					end else begin
						state_q <= ST_SUB;
					end
				end
				ST_SUB: state_q <= ST_MUL;
				ST_MUL: state_q <= ST_CMP;
				ST_CMP: begin
					if (sts.hit) begin
						kpq_q <= '0;
						if (trk_last) begin
							state_q <= ST_EMIT;
							trk_q   <= '0;
						end else begin
							state_q <= ST_RD;
							trk_q   <= trk_q + 1'b1;
						end
					end else begin
						state_q <= ST_RD;
						kpq_q   <= kpq_q + 1'b1;
					end
				end
				ST_EMIT: begin
					if (sts.out_free) begin
						if (trk_last) begin
							state_q <= ST_IDLE;
							trk_q   <= '0;
						end else begin
							trk_q <= trk_q + 1'b1;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	`GGPT_ASSERT_NEXT(a_rd_then_sub, clk, arst_n, cmd.kp_rd, state_q == ST_SUB,
		"read not followed by subtract")
	`GGPT_ASSERT_NEXT(a_emit_done, clk, arst_n, cmd.clear_kp,
		state_q == ST_IDLE && trk_q == '0, "last report did not end the frame")
	`GGPT_ASSERT_IMP(a_scan_bound, clk, arst_n, state_q == ST_SUB || state_q == ST_MUL,
		32'(kpq_q) < 32'(ggpt_pkg::MAX_KEYPOINTS), "keypoint scan beyond store")

endmodule

// ===== rtl/core/gated_greedy_point_tracker.sv =====
// Top level of the gated greedy point tracker.
// Depends on ggpt_pkg, ggpt_ctrl and ggpt_datapath.
//
// Input items arrive on the s_ stream; s_tuser carries the item kind. Init and
// keypoint items are absorbed in the idle state, which they do not leave. An
// end-of-frame item starts the match, during which s_tready stays low. Each
// track scans the stored keypoints in arrival order: a keypoint already taken
// is skipped in the read state, a keypoint that is read and tested passes the
// memory read, subtract, square and compare states, and a track without a
// match ends its scan at the end of the store. The single shared distance
// unit tests the keypoints of all tracks.
// The frame is then reported as one result item per track, track 0 first,
// at most one per cycle on the m_ stream, with m_tlast on the final track.
// A stalled receiver holds the output register and the sequencer waits; the
// next input item is taken while the final result still waits to be taken.
// Register writes on the cfg_ channel are always accepted.
// Reset zeros the track table, empties the keypoint store and loads the
// register defaults; there is no clearing pass.
module gated_greedy_point_tracker (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_tvalid,
	output logic                          s_tready,
	// s_tdata: track_index[4:0], x_coord[20:5], y_coord[36:21], zero[39:37]
	input  logic [ggpt_pkg::S_DATA_W-1:0] s_tdata,
	// s_tuser: kind[1:0]
	input  logic [1:0]                    s_tuser,
	output logic                          m_tvalid,
	input  logic                          m_tready,
	// m_tdata: out_track[4:0], pos_x[20:5], pos_y[36:21], vel_x[53:37],
	// vel_y[70:54], matched[71], frame_success[72], zero[79:73]
	output logic [ggpt_pkg::M_DATA_W-1:0] m_tdata,
	output logic                          m_tlast,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [1:0]                    cfg_index,
	input  logic [33:0]                   cfg_data
);

	ggpt_pkg::cmd_t cmd;
	ggpt_pkg::sts_t sts;

	assign cfg_ready = 1'b1;

	ggpt_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.kind     (s_tuser),
		.cmd      (cmd),
		.sts      (sts)
	);

	ggpt_datapath u_datapath (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.sts            (sts),
		.in_track_index (s_tdata[4:0]),
		.in_x           (s_tdata[20:5]),
		.in_y           (s_tdata[36:21]),
		.cfg_valid      (cfg_valid),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.m_tvalid       (m_tvalid),
		.m_tready       (m_tready),
		.m_tdata        (m_tdata),
		.m_tlast        (m_tlast)
	);

endmodule

// ===== verif/tb.sv =====
// Self-checking testbench of gated_greedy_point_tracker: tracks, keypoints and frame
// ends go in on the s_ stream, and every reported track is checked against a built-in tracker.
// Depends on ggpt_pkg and the RTL of the block; reads no file.
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int STALL_LIMIT = 20000;
	localparam int SETTLE_CYCLES = 8;
	localparam int TARGET_ITEMS = 470;
	localparam logic [1:0] KIND_UNUSED = 2'd3;
	localparam logic [33:0] GATE_MAX = '1;

	typedef struct {
		logic [4:0]         trk;
		logic signed [15:0] px;
		logic signed [15:0] py;
		logic signed [16:0] vx;
		logic signed [16:0] vy;
		logic               hit;
		logic               ok;
		logic               last;
	} track_report_t;

	logic                          clk = 1'b0;
	logic                          arst_n = 1'b0;
	logic                          s_tvalid = 1'b0;
	logic                          s_tready;
	logic [ggpt_pkg::S_DATA_W-1:0] s_tdata = '0;
	logic [1:0]                    s_tuser = '0;
	logic                          m_tvalid;
	logic                          m_tready = 1'b0;
	logic [ggpt_pkg::M_DATA_W-1:0] m_tdata;
	logic                          m_tlast;
	logic                          cfg_valid = 1'b0;
	logic                          cfg_ready;
	logic [1:0]                    cfg_index = '0;
	logic [33:0]                   cfg_data = '0;

	gated_greedy_point_tracker dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	logic [14:0]        crop_x = '0;
	logic [14:0]        crop_y = '0;
	logic [33:0]        gate = ggpt_pkg::GATE_RESET;
	logic [4:0]         need_matches = ggpt_pkg::MIN_MATCHES_RESET;
	logic signed [15:0] trk_x [ggpt_pkg::NUM_TRACKS] = '{default: '0};
	logic signed [15:0] trk_y [ggpt_pkg::NUM_TRACKS] = '{default: '0};
	logic signed [16:0] trk_vx [ggpt_pkg::NUM_TRACKS] = '{default: '0};
	logic signed [16:0] trk_vy [ggpt_pkg::NUM_TRACKS] = '{default: '0};
	logic signed [15:0] kp_x [ggpt_pkg::MAX_KEYPOINTS] = '{default: '0};
	logic signed [15:0] kp_y [ggpt_pkg::MAX_KEYPOINTS] = '{default: '0};
	int                 kp_n = 0;

	track_report_t expected_reports[$];
	int            n_errors = 0;
	int            items_sent = 0;
	int            stall_cycles = 0;
	int            rx_hold = 0;
	bit            burst = 1'b0;

	function automatic logic signed [15:0] sat16(int v);
		if (v > 32767)
			return 16'sh7fff;
		if (v < -32768)
			return 16'sh8000;
		return 16'(v);
	endfunction

	function automatic void advance_tracker(logic [1:0] kind, logic [4:0] idx,
			logic signed [15:0] x, logic signed [15:0] y);
		bit            taken [ggpt_pkg::MAX_KEYPOINTS];
		bit            found [ggpt_pkg::NUM_TRACKS];
		int            hits;
		longint        dx;
		longint        dy;
		logic [63:0]   d2;
		track_report_t rep;
		hits = 0;
		case (kind)
			ggpt_pkg::KIND_INIT: begin
				if (idx < ggpt_pkg::NUM_TRACKS) begin
					trk_x[idx] = x;
					trk_y[idx] = y;
					trk_vx[idx] = '0;
					trk_vy[idx] = '0;
				end
			end
			ggpt_pkg::KIND_KEYPOINT: begin
				if (kp_n < ggpt_pkg::MAX_KEYPOINTS) begin
					kp_x[kp_n] = sat16(int'(x) + int'(crop_x));
					kp_y[kp_n] = sat16(int'(y) + int'(crop_y));
					kp_n++;
				end
			end
			ggpt_pkg::KIND_FRAME_END: begin
				for (int t = 0; t < ggpt_pkg::NUM_TRACKS; t++) begin
					for (int q = 0; q < kp_n; q++) begin
						if (!taken[q]) begin
							dx = longint'(kp_x[q]) - longint'(trk_x[t]);
							dy = longint'(kp_y[q]) - longint'(trk_y[t]);
							d2 = dx * dx + dy * dy;
							if (d2 < 64'(gate)) begin
								trk_vx[t] = 17'(dx);
								trk_vy[t] = 17'(dy);
								trk_x[t] = kp_x[q];
								trk_y[t] = kp_y[q];
								found[t] = 1'b1;
								taken[q] = 1'b1;
								hits++;
								break;
							end
						end
					end
				end
				for (int t = 0; t < ggpt_pkg::NUM_TRACKS; t++) begin
					rep.trk = 5'(t);
					rep.px = trk_x[t];
					rep.py = trk_y[t];
					rep.vx = trk_vx[t];
					rep.vy = trk_vy[t];
					rep.hit = found[t];
					rep.ok = (hits >= int'(need_matches));
					rep.last = (t == ggpt_pkg::NUM_TRACKS - 1);
					expected_reports.push_back(rep);
				end
				kp_n = 0;
			end
			default: ;
		endcase
	endfunction

	task automatic send_item(logic [1:0] kind, logic [4:0] idx, logic signed [15:0] x,
			logic signed [15:0] y);
		int gap;
		gap = burst ? 0 : $urandom_range(0, 8);
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {3'b000, y, x, idx};
		s_tuser <= kind;
		do @(posedge clk); while (!s_tready);
		advance_tracker(kind, idx, x, y);
		if (kind != KIND_UNUSED &&
				!(kind == ggpt_pkg::KIND_INIT && idx >= ggpt_pkg::NUM_TRACKS))
			items_sent++;
	endtask

	task automatic send_near_keypoint(int t, int spread);
		int ox;
		int oy;
		ox = $urandom_range(0, 2 * spread);
		oy = $urandom_range(0, 2 * spread);
		ox -= spread;
		oy -= spread;
		send_item(ggpt_pkg::KIND_KEYPOINT, 5'($urandom()),
			sat16(int'(trk_x[t]) + ox - int'(crop_x)),
			sat16(int'(trk_y[t]) + oy - int'(crop_y)));
	endtask

	task automatic wait_drained();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (expected_reports.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(logic [1:0] index, logic [33:0] value);
		cfg_valid <= 1'b1;
		cfg_index <= index;
		cfg_data <= value;
		do @(posedge clk); while (!cfg_ready);
		case (index)
			ggpt_pkg::REG_CROP_X:      crop_x = value[14:0];
			ggpt_pkg::REG_CROP_Y:      crop_y = value[14:0];
			ggpt_pkg::REG_GATE:        gate = value;
			ggpt_pkg::REG_MIN_MATCHES: need_matches = value[4:0];
			default: ;
		endcase
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	function automatic void check_field(string name, int want, int got);
		if (want != got) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			n_errors++;
		end
	endfunction

	always @(posedge clk) begin : report_check
		track_report_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (expected_reports.size() == 0) begin
				$error("unexpected result item for track %0d", m_tdata[4:0]);
				n_errors++;
			end else begin
				want = expected_reports.pop_front();
				check_field("out_track", want.trk, m_tdata[4:0]);
				check_field("pos_x", want.px, $signed(m_tdata[20:5]));
				check_field("pos_y", want.py, $signed(m_tdata[36:21]));
				check_field("vel_x", want.vx, $signed(m_tdata[53:37]));
				check_field("vel_y", want.vy, $signed(m_tdata[70:54]));
				check_field("matched", want.hit, m_tdata[71]);
				check_field("frame_success", want.ok, m_tdata[72]);
				check_field("last_result", want.last, m_tlast);
			end
		end
	end

	initial begin : result_sink
		int gap;
		forever begin
			if (rx_hold > 0) begin
				m_tready <= 1'b0;
				repeat (rx_hold) @(posedge clk);
				rx_hold = 0;
			end
			gap = burst ? 0 : $urandom_range(0, 8);
			if (gap > 0) begin
				m_tready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			m_tready <= 1'b1;
			do @(posedge clk); while (!(m_tvalid && m_tready) && rx_hold == 0);
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready) ||
				(cfg_valid && cfg_ready))
			stall_cycles <= 0;
		else
			stall_cycles <= stall_cycles + 1;
		if (stall_cycles >= STALL_LIMIT) begin
			$display("FAILED: results differ");
			$finish;
		end
	end

	task automatic test_gate_boundary();
		send_item(ggpt_pkg::KIND_INIT, 0, 0, 0);
		send_item(ggpt_pkg::KIND_INIT, 1, 4000, -4000);
		send_item(ggpt_pkg::KIND_KEYPOINT, 0, 320, 0);
		send_item(ggpt_pkg::KIND_KEYPOINT, 0, 0, -319);
		send_item(ggpt_pkg::KIND_KEYPOINT, 0, 4100, -4100);
		send_item(ggpt_pkg::KIND_FRAME_END, 0, 0, 0);
	endtask

	task automatic test_ignored_items();
		send_item(ggpt_pkg::KIND_INIT, 20, 100, 100);
		send_item(ggpt_pkg::KIND_INIT, 31, -1, -1);
		send_item(KIND_UNUSED, 5, 7, 7);
		send_item(ggpt_pkg::KIND_INIT, 2, -500, 700);
		send_item(ggpt_pkg::KIND_FRAME_END, 0, 0, 0);
		wait_drained();
		write_reg(ggpt_pkg::REG_GATE, '0);
		send_item(ggpt_pkg::KIND_KEYPOINT, 0, -500, 700);
		send_item(ggpt_pkg::KIND_FRAME_END, 0, 0, 0);
		wait_drained();
		write_reg(ggpt_pkg::REG_GATE, ggpt_pkg::GATE_RESET);
	endtask

	task automatic test_extremes();
		wait_drained();
		write_reg(ggpt_pkg::REG_GATE, GATE_MAX);
		write_reg(ggpt_pkg::REG_MIN_MATCHES, 0);
		send_item(ggpt_pkg::KIND_INIT, 0, -32768, -32768);
		send_item(ggpt_pkg::KIND_INIT, 1, 32767, 32767);
		send_item(ggpt_pkg::KIND_KEYPOINT, 0, 32767, 32767);
		send_item(ggpt_pkg::KIND_KEYPOINT, 0, -32768, -32768);
		send_item(ggpt_pkg::KIND_FRAME_END, 0, 0, 0);
		wait_drained();
		write_reg(ggpt_pkg::REG_CROP_X, 32767);
		write_reg(ggpt_pkg::REG_CROP_Y, 32767);
		write_reg(ggpt_pkg::REG_MIN_MATCHES, 20);
		send_item(ggpt_pkg::KIND_KEYPOINT, 0, 32767, -32768);
		send_item(ggpt_pkg::KIND_KEYPOINT, 0, 1, 0);
		send_item(ggpt_pkg::KIND_FRAME_END, 0, 0, 0);
		wait_drained();
		write_reg(ggpt_pkg::REG_CROP_X, 0);
		write_reg(ggpt_pkg::REG_CROP_Y, 0);
		write_reg(ggpt_pkg::REG_GATE, ggpt_pkg::GATE_RESET);
	endtask

	// The sink stalls long enough for the output register and the input side to back up.
	task automatic test_output_stall();
		wait_drained();
		rx_hold = 1500;
		for (int t = 0; t < 3; t++)
			send_near_keypoint(t, 200);
		send_item(ggpt_pkg::KIND_FRAME_END, 0, 0, 0);
		for (int t = 3; t < 6; t++)
			send_near_keypoint(t, 200);
		send_item(ggpt_pkg::KIND_FRAME_END, 0, 0, 0);
		send_item(ggpt_pkg::KIND_INIT, 7, 1234, -1234);
		send_item(ggpt_pkg::KIND_INIT, 8, -2000, 2000);
		wait_drained();
	endtask

	task automatic test_full_store();
		for (int i = 0; i < ggpt_pkg::MAX_KEYPOINTS + 6; i++)
			send_near_keypoint($urandom_range(0, ggpt_pkg::NUM_TRACKS - 1), 300);
		send_item(ggpt_pkg::KIND_FRAME_END, 0, 0, 0);
	endtask

	task automatic test_random_frames();
		int px;
		int py;
		int start;
		while (items_sent < TARGET_ITEMS) begin
			if ($urandom_range(0, 2) == 0) begin
				wait_drained();
				case ($urandom_range(0, 3))
					0: write_reg(ggpt_pkg::REG_CROP_X, ($urandom_range(0, 1) == 0) ?
						34'($urandom_range(0, 255)) : 34'($urandom_range(0, 32767)));
					1: write_reg(ggpt_pkg::REG_CROP_Y, ($urandom_range(0, 1) == 0) ?
						34'($urandom_range(0, 255)) : 34'($urandom_range(0, 32767)));
					2: case ($urandom_range(0, 3))
						0: write_reg(ggpt_pkg::REG_GATE, '0);
						1: write_reg(ggpt_pkg::REG_GATE, GATE_MAX);
						2: write_reg(ggpt_pkg::REG_GATE,
							34'({$urandom_range(0, 3), $urandom()}));
						default: write_reg(ggpt_pkg::REG_GATE,
							34'($urandom_range(1000, 400000)));
					endcase
					default: write_reg(ggpt_pkg::REG_MIN_MATCHES,
						34'($urandom_range(0, 20)));
				endcase
			end
			burst = ($urandom_range(0, 3) == 0);
			if ($urandom_range(0, 4) != 0) begin
				if ($urandom_range(0, 2) == 0) begin
					repeat ($urandom_range(1, 6)) begin
						px = $urandom_range(0, 8000);
						py = $urandom_range(0, 8000);
						send_item(ggpt_pkg::KIND_INIT,
							5'($urandom_range(0, ggpt_pkg::NUM_TRACKS - 1)),
							16'(px - 4000), 16'(py - 4000));
					end
				end
				start = $urandom_range(0, ggpt_pkg::NUM_TRACKS - 1);
				for (int i = 0; i < ggpt_pkg::NUM_TRACKS; i++) begin
					if ($urandom_range(0, 9) < 8)
						send_near_keypoint((start + i) % ggpt_pkg::NUM_TRACKS, 400);
					if ($urandom_range(0, 19) == 0)
						send_item(ggpt_pkg::KIND_KEYPOINT, 5'($urandom()),
							16'($urandom()), 16'($urandom()));
					if ($urandom_range(0, 39) == 0)
						send_item(KIND_UNUSED, 5'($urandom()), 16'($urandom()),
							16'($urandom()));
				end
				send_item(ggpt_pkg::KIND_FRAME_END, 5'($urandom()), 16'($urandom()),
					16'($urandom()));
			end else begin
				repeat ($urandom_range(1, 8))
					send_item(2'($urandom()), 5'($urandom()), 16'($urandom()),
						16'($urandom()));
			end
		end
		burst = 1'b0;
	endtask

	initial begin
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_gate_boundary();
		test_ignored_items();
		test_extremes();
		test_output_stall();
		test_full_store();
		test_random_frames();
		wait_drained();
		repeat (50) @(posedge clk);
		if (n_errors == 0)
			$display("PASSED: all results match");
		else
			$display("FAILED: results differ");
		$finish;
	end

endmodule
